// ----- sv/lav_pkg.sv -----
// lav_pkg: shared word format, payload structs and saturation helper for the look-at block
// used by lav_bscale, lav_norm and look_at_view_matrix; depends on nothing
package lav_pkg;

   localparam int WORD_WIDTH     = 32;
   localparam int FRAC_BITS      = 16;
   // the largest block-scaled magnitude sits in [2^29, 2^30)
   localparam int NORM_BITS      = 30;
   // sum of three squares, its root and the reciprocal 2^61 / root
   localparam int SUM_WIDTH      = 62;
   localparam int ROOT_WIDTH     = 31;
   localparam int RECIP_WIDTH    = 33;
   localparam int RECIP_EXP      = 61;
   localparam int SQRT_STEPS     = 31;
   localparam int SQRT_PER_STAGE = 2;
   localparam int DIV_STEPS      = 33;
   localparam int DIV_PER_STAGE  = 3;
   // wide signed width used ahead of saturation
   localparam int SAT_WIDTH      = 2 * WORD_WIDTH + 40;

   typedef logic signed [WORD_WIDTH-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   typedef struct packed {
      word_type eye_x;
      word_type eye_y;
      word_type eye_z;
      word_type center_x;
      word_type center_y;
      word_type center_z;
      word_type up_x;
      word_type up_y;
      word_type up_z;
   } req_type;

   typedef struct packed {
      word_type side_x;
      word_type side_y;
      word_type side_z;
      word_type upaxis_x;
      word_type upaxis_y;
      word_type upaxis_z;
      word_type back_x;
      word_type back_y;
      word_type back_z;
      word_type shift_x;
      word_type shift_y;
      word_type shift_z;
   } rsp_type;

   function automatic word_type sat_word(input logic signed [SAT_WIDTH-1:0] x);
      if (x > SAT_WIDTH'(WORD_MAX)) begin
         return WORD_MAX;
      end else if (x < SAT_WIDTH'(WORD_MIN)) begin
         return WORD_MIN;
      end else begin
         return x[WORD_WIDTH-1:0];
      end
   endfunction

endpackage

// ----- sv/look_at_view_matrix.sv -----
// look_at_view_matrix: right-handed look-at view matrix rows in signed fixed point
// depends on lav_pkg, lav_bscale and lav_norm
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  lav_pkg::req_type: eye, center, up
//  rsp      out        rsp_valid/rsp_ready  lav_pkg::rsp_type: side, upaxis, back, shift
//
// one word enters per cycle while req_ready is high; rsp_valid rises once a word has
// passed every stage (per normalisation pipeline root 16, reciprocal 11 stages)
// reset clears only the valid bits of every stage and of the output pair
// all stages move together while the skid register is empty; a result that finds
// rsp stalled drops into the skid register, and req_ready falls only once it is full
module look_at_view_matrix #(
   parameter int FRAC_BITS = lav_pkg::FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lav_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lav_pkg::rsp_type  rsp_data
);

   localparam int W   = lav_pkg::WORD_WIDTH;
   localparam int NB  = lav_pkg::NORM_BITS;
   localparam int SW  = lav_pkg::SAT_WIDTH;
   localparam int DW  = W + 1;          // center - eye
   localparam int UW  = NB + 1;         // block-scaled up, signed
   localparam int XPW = W + UW;         // f * up product
   localparam int RW  = XPW + 1;        // raw side vector
   localparam int PPW = 2 * W;          // axis * axis or axis * eye
   localparam int DSW = PPW + 2;        // three-term dot sum

   // rounds x / 2^FRAC_BITS half toward plus infinity
   function automatic logic signed [SW-1:0] round_frac(input logic signed [SW-1:0] x);
      logic signed [SW-1:0] half;
      logic signed [SW-1:0] y;
      half = $signed(SW'(1) << (FRAC_BITS - 1));
      y    = x + half;
      return y >>> FRAC_BITS;
   endfunction

   logic en;
   logic out_v_ff, sk_v_ff;
   lav_pkg::rsp_type out_d_ff, sk_d_ff, rsp_nx;

   // whole pipeline advances while the skid register is free
   assign en        = !sk_v_ff;
   assign req_ready = en;

   // stage 0: forward difference, eye and up ride along
   logic                  v0_ff;
   logic [2:0][DW-1:0]    d0_ff;
   logic [5:0][W-1:0]     side0_ff;    // [2:0] eye, [5:3] up

   // forward normalisation
   logic                  n1_v;
   logic [2:0][W-1:0]     fwd;
   logic [5:0][W-1:0]     n1_side;

   // up block scaling, eye and forward ride along
   logic                  bu_v;
   logic [2:0][NB-1:0]    bu_mag;
   logic [2:0]            bu_neg;
   logic [5:0][W-1:0]     bu_side;     // [2:0] eye, [5:3] f

   // cross product f x up
   logic                  v1_ff, v2_ff, v3_ff;
   logic [2:0][UW-1:0]    upv1_ff;
   logic [5:0][W-1:0]     side1_ff, side2_ff, side3_ff;
   logic [5:0][XPW-1:0]   pr2_ff;
   logic [2:0][RW-1:0]    r3_ff;

   // side normalisation
   logic                  n2_v;
   logic [2:0][W-1:0]     sax;
   logic [5:0][W-1:0]     n2_side;     // [2:0] eye, [5:3] f

   // true up and translations
   logic                  v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic [5:0][PPW-1:0]   pu4_ff;
   logic [2:0][PPW-1:0]   ps4_ff, pf4_ff;
   logic [2:0][W-1:0]     s4_ff, s5_ff, s6_ff, s7_ff, s8_ff;
   logic [5:0][W-1:0]     side4_ff, side5_ff;
   logic [2:0][PPW:0]     ur5_ff;
   logic signed [DSW-1:0] sd5_ff, fd5_ff;
   logic [2:0][W-1:0]     eye6_ff;
   lav_pkg::word_type     u6_in [3];
   lav_pkg::word_type     bk6_in [3];
   logic [2:0][W-1:0]     u6_ff, u7_ff, u8_ff;
   logic [2:0][W-1:0]     bk6_ff, bk7_ff, bk8_ff;
   lav_pkg::word_type     shx6_ff, shx7_ff, shx8_ff;
   lav_pkg::word_type     shz6_ff, shz7_ff, shz8_ff;
   logic [2:0][PPW-1:0]   pe7_ff;
   logic signed [DSW-1:0] ud8_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d0_ff[0] <= DW'(req_data.center_x) - DW'(req_data.eye_x);
         d0_ff[1] <= DW'(req_data.center_y) - DW'(req_data.eye_y);
         d0_ff[2] <= DW'(req_data.center_z) - DW'(req_data.eye_z);
         side0_ff <= {req_data.up_z, req_data.up_y, req_data.up_x,
                      req_data.eye_z, req_data.eye_y, req_data.eye_x};
      end
   end

   lav_norm #(
      .IN_WIDTH   (DW),
      .SIDE_WIDTH (6 * W),
      .FRAC_BITS  (FRAC_BITS)
   ) u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v0_ff),
      .in_vec    (d0_ff),
      .in_side   (side0_ff),
      .out_valid (n1_v),
      .out_vec   (fwd),
      .out_side  (n1_side)
   );

   lav_bscale #(
      .IN_WIDTH   (W),
      .SIDE_WIDTH (6 * W)
   ) u_bscale_up (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (n1_v),
      .in_vec    (n1_side[5:3]),
      .in_side   ({fwd, n1_side[2:0]}),
      .out_valid (bu_v),
      .out_mag   (bu_mag),
      .out_neg   (bu_neg),
      .out_side  (bu_side)
   );

   // signed up, then the six products, then the differences
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            upv1_ff[i] <= bu_neg[i] ? -{1'b0, bu_mag[i]} : {1'b0, bu_mag[i]};
         end
         side1_ff <= bu_side;

         pr2_ff[0] <= XPW'($signed(side1_ff[4])) * XPW'($signed(upv1_ff[2]));
         pr2_ff[1] <= XPW'($signed(side1_ff[5])) * XPW'($signed(upv1_ff[1]));
         pr2_ff[2] <= XPW'($signed(side1_ff[5])) * XPW'($signed(upv1_ff[0]));
         pr2_ff[3] <= XPW'($signed(side1_ff[3])) * XPW'($signed(upv1_ff[2]));
         pr2_ff[4] <= XPW'($signed(side1_ff[3])) * XPW'($signed(upv1_ff[1]));
         pr2_ff[5] <= XPW'($signed(side1_ff[4])) * XPW'($signed(upv1_ff[0]));
         side2_ff  <= side1_ff;

         for (int i = 0; i < 3; i++) begin
            r3_ff[i] <= RW'($signed(pr2_ff[2*i])) - RW'($signed(pr2_ff[2*i+1]));
         end
         side3_ff <= side2_ff;
      end
   end

   lav_norm #(
      .IN_WIDTH   (RW),
      .SIDE_WIDTH (6 * W),
      .FRAC_BITS  (FRAC_BITS)
   ) u_norm_side (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_vec    (r3_ff),
      .in_side   (side3_ff),
      .out_valid (n2_v),
      .out_vec   (sax),
      .out_side  (n2_side)
   );

   // u = s x f rounded, translations from s and f, back = -f
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         u6_in[i]  = lav_pkg::sat_word(round_frac(SW'($signed(ur5_ff[i]))));
         bk6_in[i] = lav_pkg::sat_word(-SW'($signed(side5_ff[3+i])));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // products of u = s x f, s.eye and f.eye
         pu4_ff[0] <= PPW'($signed(sax[1])) * PPW'($signed(n2_side[5]));
         pu4_ff[1] <= PPW'($signed(sax[2])) * PPW'($signed(n2_side[4]));
         pu4_ff[2] <= PPW'($signed(sax[2])) * PPW'($signed(n2_side[3]));
         pu4_ff[3] <= PPW'($signed(sax[0])) * PPW'($signed(n2_side[5]));
         pu4_ff[4] <= PPW'($signed(sax[0])) * PPW'($signed(n2_side[4]));
         pu4_ff[5] <= PPW'($signed(sax[1])) * PPW'($signed(n2_side[3]));
         for (int i = 0; i < 3; i++) begin
            ps4_ff[i] <= PPW'($signed(sax[i])) * PPW'($signed(n2_side[i]));
            pf4_ff[i] <= PPW'($signed(n2_side[3+i])) * PPW'($signed(n2_side[i]));
         end
         s4_ff    <= sax;
         side4_ff <= n2_side;

         for (int i = 0; i < 3; i++) begin
            ur5_ff[i] <= (PPW+1)'($signed(pu4_ff[2*i])) - (PPW+1)'($signed(pu4_ff[2*i+1]));
         end
         sd5_ff   <= DSW'($signed(ps4_ff[0])) + DSW'($signed(ps4_ff[1]))
                     + DSW'($signed(ps4_ff[2]));
         fd5_ff   <= DSW'($signed(pf4_ff[0])) + DSW'($signed(pf4_ff[1]))
                     + DSW'($signed(pf4_ff[2]));
         s5_ff    <= s4_ff;
         side5_ff <= side4_ff;

         for (int i = 0; i < 3; i++) begin
            u6_ff[i]  <= u6_in[i];
            bk6_ff[i] <= bk6_in[i];
         end
         shx6_ff <= lav_pkg::sat_word(-round_frac(SW'(sd5_ff)));
         shz6_ff <= lav_pkg::sat_word(round_frac(SW'(fd5_ff)));
         s6_ff   <= s5_ff;
         eye6_ff <= side5_ff[2:0];

         for (int i = 0; i < 3; i++) begin
            pe7_ff[i] <= PPW'($signed(u6_ff[i])) * PPW'($signed(eye6_ff[i]));
         end
         s7_ff   <= s6_ff;
         u7_ff   <= u6_ff;
         bk7_ff  <= bk6_ff;
         shx7_ff <= shx6_ff;
         shz7_ff <= shz6_ff;

         ud8_ff  <= DSW'($signed(pe7_ff[0])) + DSW'($signed(pe7_ff[1]))
                    + DSW'($signed(pe7_ff[2]));
         s8_ff   <= s7_ff;
         u8_ff   <= u7_ff;
         bk8_ff  <= bk7_ff;
         shx8_ff <= shx7_ff;
         shz8_ff <= shz7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
         v1_ff <= bu_v;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= n2_v;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   // last step: -u.eye, then the result word
   always_comb begin
      rsp_nx.side_x   = s8_ff[0];
      rsp_nx.side_y   = s8_ff[1];
      rsp_nx.side_z   = s8_ff[2];
      rsp_nx.upaxis_x = u8_ff[0];
      rsp_nx.upaxis_y = u8_ff[1];
      rsp_nx.upaxis_z = u8_ff[2];
      rsp_nx.back_x   = bk8_ff[0];
      rsp_nx.back_y   = bk8_ff[1];
      rsp_nx.back_z   = bk8_ff[2];
      rsp_nx.shift_x  = shx8_ff;
      rsp_nx.shift_y  = lav_pkg::sat_word(-round_frac(SW'(ud8_ff)));
      rsp_nx.shift_z  = shz8_ff;
   end

   // output register plus skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else if (sk_v_ff) begin
         if (rsp_ready) begin
            sk_v_ff <= 1'b0;
         end
      end else if (v8_ff) begin
         if (out_v_ff && !rsp_ready) begin
            sk_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sk_v_ff) begin
         if (rsp_ready) begin
            out_d_ff <= sk_d_ff;
         end
      end else if (v8_ff) begin
         if (out_v_ff && !rsp_ready) begin
            sk_d_ff <= rsp_nx;
         end else begin
            out_d_ff <= rsp_nx;
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_d_ff;

endmodule

// ----- sv/lav_bscale.sv -----
// lav_bscale: three-stage block scaling of a signed 3-vector, max magnitude in [2^29, 2^30)
// depends on lav_pkg
module lav_bscale #(
   parameter int IN_WIDTH   = 33,
   parameter int SIDE_WIDTH = 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic [2:0][IN_WIDTH-1:0]                in_vec,
   input  logic [SIDE_WIDTH-1:0]                   in_side,
   output logic                                    out_valid,
   output logic [2:0][lav_pkg::NORM_BITS-1:0]      out_mag,
   output logic [2:0]                              out_neg,
   output logic [SIDE_WIDTH-1:0]                   out_side
);

   localparam int NB = lav_pkg::NORM_BITS;
   localparam int PW = $clog2(IN_WIDTH > NB ? IN_WIDTH : NB);
   localparam int XW = IN_WIDTH + NB;
   localparam logic [PW-1:0] TOP_POS = PW'(NB - 1);

   logic                       v1_ff, v2_ff, v3_ff;
   logic [2:0][IN_WIDTH-1:0]   mag1_in, mag1_ff, mag2_ff;
   logic [2:0]                 neg1_ff, neg2_ff, neg3_ff;
   logic [PW-1:0]              pos2_in, pos2_ff;
   logic [2:0][NB-1:0]         mag3_in, mag3_ff;
   logic [SIDE_WIDTH-1:0]      side1_ff, side2_ff, side3_ff;

   // magnitudes, sign kept apart
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag1_in[i] = in_vec[i][IN_WIDTH-1] ? (~in_vec[i] + IN_WIDTH'(1)) : in_vec[i];
      end
   end

   // leading one of the largest magnitude equals that of the or of all three
   always_comb begin : lead_one
      logic [IN_WIDTH-1:0] any;
      any     = mag1_ff[0] | mag1_ff[1] | mag1_ff[2];
      pos2_in = '0;
      for (int b = 0; b < IN_WIDTH; b++) begin
         if (any[b]) begin
            pos2_in = PW'(b);
         end
      end
   end

   always_comb begin : align
      logic [XW-1:0] wide;
      wide = '0;
      for (int i = 0; i < 3; i++) begin
         wide = XW'(mag2_ff[i]);
         if (pos2_ff >= TOP_POS) begin
            wide = wide >> (pos2_ff - TOP_POS);
         end else begin
            wide = wide << (TOP_POS - pos2_ff);
         end
         mag3_in[i] = wide[NB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff  <= mag1_in;
         neg1_ff  <= {in_vec[2][IN_WIDTH-1], in_vec[1][IN_WIDTH-1], in_vec[0][IN_WIDTH-1]};
         side1_ff <= in_side;
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
         pos2_ff  <= pos2_in;
         side2_ff <= side1_ff;
         mag3_ff  <= mag3_in;
         neg3_ff  <= neg2_ff;
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_mag   = mag3_ff;
   assign out_neg   = neg3_ff;
   assign out_side  = side3_ff;

endmodule

// ----- sv/lav_norm.sv -----
// lav_norm: pipelined vector normalisation (block scale, square sum, root, reciprocal, scale)
// depends on lav_pkg and lav_bscale
module lav_norm #(
   parameter int IN_WIDTH   = 33,
   parameter int SIDE_WIDTH = 1,
   parameter int FRAC_BITS  = lav_pkg::FRAC_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic [2:0][IN_WIDTH-1:0]                in_vec,
   input  logic [SIDE_WIDTH-1:0]                   in_side,
   output logic                                    out_valid,
   output logic [2:0][lav_pkg::WORD_WIDTH-1:0]     out_vec,
   output logic [SIDE_WIDTH-1:0]                   out_side
);

   localparam int NB     = lav_pkg::NORM_BITS;
   localparam int CW     = 3 * NB + 3 + SIDE_WIDTH;
   localparam int SUMW   = lav_pkg::SUM_WIDTH;
   localparam int ROOTW  = lav_pkg::ROOT_WIDTH;
   localparam int QW     = lav_pkg::RECIP_WIDTH;
   localparam int REMW   = ROOTW;
   localparam int SQ_PER = lav_pkg::SQRT_PER_STAGE;
   localparam int DV_PER = lav_pkg::DIV_PER_STAGE;
   localparam int SQ_ST  = (lav_pkg::SQRT_STEPS + SQ_PER - 1) / SQ_PER;
   localparam int DV_ST  = (lav_pkg::DIV_STEPS + DV_PER - 1) / DV_PER;
   localparam int PRODW  = NB + QW;
   localparam int RSH    = lav_pkg::RECIP_EXP - FRAC_BITS;
   // long division starts with the numerator bits above the first quotient bit
   localparam int REM0_EXP = lav_pkg::RECIP_EXP - lav_pkg::DIV_STEPS;
   localparam int SATW   = lav_pkg::SAT_WIDTH;

   logic                    bs_valid;
   logic [2:0][NB-1:0]      bs_mag;
   logic [2:0]              bs_neg;
   logic [SIDE_WIDTH-1:0]   bs_side;

   lav_bscale #(
      .IN_WIDTH   (IN_WIDTH),
      .SIDE_WIDTH (SIDE_WIDTH)
   ) u_bscale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid),
      .in_vec    (in_vec),
      .in_side   (in_side),
      .out_valid (bs_valid),
      .out_mag   (bs_mag),
      .out_neg   (bs_neg),
      .out_side  (bs_side)
   );

   // squares
   logic                    v4_ff;
   logic [2:0][2*NB-1:0]    sq4_ff;
   logic [CW-1:0]           c4_ff;

   // root stages, index 0 holds the sum
   logic [SQ_ST:0]          sv_ff;
   logic [SUMW-1:0]         sx_ff [SQ_ST+1];
   logic [SUMW-1:0]         sr_ff [SQ_ST+1];
   logic [CW-1:0]           sc_ff [SQ_ST+1];
   logic [SUMW-1:0]         sx_in [SQ_ST];
   logic [SUMW-1:0]         sr_in [SQ_ST];

   // reciprocal stages
   logic [DV_ST:0]          dv_ff;
   logic [ROOTW-1:0]        dl_ff [DV_ST+1];
   logic [REMW-1:0]         dr_ff [DV_ST+1];
   logic [QW-1:0]           dq_ff [DV_ST+1];
   logic [CW-1:0]           dc_ff [DV_ST+1];
   logic [REMW-1:0]         dr_in [DV_ST];
   logic [QW-1:0]           dq_in [DV_ST];

   // scale and round
   logic                    pv_ff;
   logic [2:0][PRODW-1:0]   pm_ff;
   logic [2:0]              pn_ff;
   logic [SIDE_WIDTH-1:0]   ps_ff;
   logic                    ov_ff;
   logic [2:0][lav_pkg::WORD_WIDTH-1:0] ovec_ff, ovec_in;
   logic [SIDE_WIDTH-1:0]   os_ff;

   logic [2:0][NB-1:0]      fin_mag;
   logic [QW-1:0]           fin_recip;

   generate
      for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
         always_comb begin
            logic [SUMW-1:0] x;
            logic [SUMW-1:0] r;
            logic [SUMW-1:0] bitv;
            logic [SUMW:0]   trial;
            x     = sx_ff[g];
            r     = sr_ff[g];
            bitv  = '0;
            trial = '0;
            for (int t = 0; t < SQ_PER; t++) begin
               if (g * SQ_PER + t < lav_pkg::SQRT_STEPS) begin
                  bitv  = SUMW'(1) << (2 * (lav_pkg::SQRT_STEPS - 1 - (g * SQ_PER + t)));
                  trial = {1'b0, r} + {1'b0, bitv};
                  if ({1'b0, x} >= trial) begin
                     x = x - trial[SUMW-1:0];
                     r = (r >> 1) + bitv;
                  end else begin
                     r = r >> 1;
                  end
               end
            end
            sx_in[g] = x;
            sr_in[g] = r;
         end
      end

      for (genvar k = 0; k < DV_ST; k++) begin : g_div
         always_comb begin
            logic [REMW-1:0] rem;
            logic [REMW:0]   rem2;
            logic [QW-1:0]   q;
            logic            qb;
            rem  = dr_ff[k];
            q    = dq_ff[k];
            rem2 = '0;
            qb   = 1'b0;
            for (int t = 0; t < DV_PER; t++) begin
               if (k * DV_PER + t < lav_pkg::DIV_STEPS) begin
                  rem2 = {rem, 1'b0};
                  if (rem2 >= {1'b0, dl_ff[k]}) begin
                     rem2 = rem2 - {1'b0, dl_ff[k]};
                     qb   = 1'b1;
                  end else begin
                     qb   = 1'b0;
                  end
                  rem = rem2[REMW-1:0];
                  q   = {q[QW-2:0], qb};
               end
            end
            dr_in[k] = rem;
            dq_in[k] = q;
         end
      end
   endgenerate

   assign fin_mag   = dc_ff[DV_ST][3*NB-1:0];
   assign fin_recip = dq_ff[DV_ST];

   // round half up, put the sign back, saturate
   always_comb begin : rnd
      logic [PRODW:0]                sum;
      logic [PRODW-RSH:0]            qq;
      logic signed [SATW-1:0]        mv;
      sum = '0;
      qq  = '0;
      mv  = '0;
      for (int i = 0; i < 3; i++) begin
         sum = {1'b0, pm_ff[i]} + ((PRODW+1)'(1) << (RSH - 1));
         qq  = sum[PRODW:RSH];
         mv  = SATW'(qq);
         if (pn_ff[i]) begin
            mv = -mv;
         end
         ovec_in[i] = lav_pkg::sat_word(mv);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         sv_ff <= '0;
         dv_ff <= '0;
         pv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= bs_valid;
         sv_ff <= {sv_ff[SQ_ST-1:0], v4_ff};
         dv_ff <= {dv_ff[DV_ST-1:0], sv_ff[SQ_ST]};
         pv_ff <= dv_ff[DV_ST];
         ov_ff <= pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= bs_mag[i] * bs_mag[i];
         end
         c4_ff <= {bs_side, bs_neg, bs_mag};

         sx_ff[0] <= SUMW'(sq4_ff[0]) + SUMW'(sq4_ff[1]) + SUMW'(sq4_ff[2]);
         sr_ff[0] <= '0;
         sc_ff[0] <= c4_ff;
         for (int g = 0; g < SQ_ST; g++) begin
            sx_ff[g+1] <= sx_in[g];
            sr_ff[g+1] <= sr_in[g];
            sc_ff[g+1] <= sc_ff[g];
         end

         dl_ff[0] <= sr_ff[SQ_ST][ROOTW-1:0];
         dr_ff[0] <= REMW'(1) << REM0_EXP;
         dq_ff[0] <= '0;
         dc_ff[0] <= sc_ff[SQ_ST];
         for (int k = 0; k < DV_ST; k++) begin
            dl_ff[k+1] <= dl_ff[k];
            dr_ff[k+1] <= dr_in[k];
            dq_ff[k+1] <= dq_in[k];
            dc_ff[k+1] <= dc_ff[k];
         end

         for (int i = 0; i < 3; i++) begin
            pm_ff[i] <= PRODW'(fin_mag[i]) * PRODW'(fin_recip);
         end
         pn_ff <= dc_ff[DV_ST][3*NB+2:3*NB];
         ps_ff <= dc_ff[DV_ST][CW-1:3*NB+3];

         ovec_ff <= ovec_in;
         os_ff   <= ps_ff;
      end
   end

   assign out_valid = ov_ff;
   assign out_vec   = ovec_ff;
   assign out_side  = os_ff;

endmodule
